// ===== rtl/sorted_char_list_engine_defines.svh =====
// assertion macros for the sorted character list engine
`ifndef SORTED_CHAR_LIST_ENGINE_DEFINES_SVH
`define SORTED_CHAR_LIST_ENGINE_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("property failed");
`define ASSERT_NEVER(lbl, clk, rst, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst, prop)
`define ASSERT_NEVER(lbl, clk, rst, expr)
`endif

`endif

// ===== rtl/scle_pkg.sv =====
package scle_pkg;

  localparam logic [1:0] OP_INSERT  = 2'd0;
  localparam logic [1:0] OP_DELETE  = 2'd1;
  localparam logic [1:0] OP_REPLACE = 2'd2;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_EMPTY     = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic signed [7:0] value;
    logic signed [7:0] replacement;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [4:0] entry_count;
  } rsp_t;

  // per cycle commands broadcast to every cell
  typedef struct packed {
    logic insert;
    logic remove;
    logic replace;
  } cell_ctl_t;

  // running flags handed from one cell to the next
  typedef struct packed {
    logic ins_seen;
    logic eq_seen;
  } cell_link_t;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

endpackage

// ===== rtl/scle_cell.sv =====
module scle_cell (
  input  logic                  clk,
  input  scle_pkg::cell_ctl_t   ctl,
  input  logic signed [7:0]     value,
  input  logic signed [7:0]     replacement,
  input  logic                  occupied,
  input  logic signed [7:0]     left_entry,
  input  logic signed [7:0]     right_entry,
  input  scle_pkg::cell_link_t  link_in,
  output scle_pkg::cell_link_t  link_out,
  output logic signed [7:0]     entry
);

  logic ins_cand;
  logic eq_match;
  logic ins_here;
  logic eq_here;
  logic signed [7:0] entry_next;

  always_comb begin
    ins_cand = !(occupied && (value > entry));
    eq_match = occupied && (entry == value);
    ins_here = ins_cand && !link_in.ins_seen;
    eq_here  = eq_match && !link_in.eq_seen;
    link_out.ins_seen = link_in.ins_seen | ins_cand;
    link_out.eq_seen  = link_in.eq_seen | eq_match;
  end

  always_comb begin
    entry_next = entry;
    if (ctl.insert && link_in.ins_seen) begin
      entry_next = left_entry;
    end else if (ctl.insert && ins_here) begin
      entry_next = value;
    end else if (ctl.remove && (link_in.eq_seen || eq_match)) begin
      entry_next = right_entry;
    end else if (ctl.replace && eq_here) begin
      entry_next = replacement;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule

// ===== rtl/sorted_char_list_engine.sv =====
// Ordered list of up to LIST_DEPTH signed characters, one insert, delete or
// replace per item, one result per item carrying a status and the entry count
// after the operation. Each item has a capture step that registers the request
// and an operation step in which the row of cells compares every held entry
// against the value, passes the first-match flags along the row and shifts or
// rewrites its entries in the same edge. A result waits in an output register
// while the next item is taken in; the operation step holds only while that
// register is full. The list is empty after reset and needs no clearing pass.
`include "sorted_char_list_engine_defines.svh"

module sorted_char_list_engine #(
  parameter int LIST_DEPTH = 16
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  scle_pkg::req_t req,
  output logic           rsp_valid,
  input  logic           rsp_ready,
  output scle_pkg::rsp_t rsp
);

  localparam int CW = $clog2(LIST_DEPTH + 1);

  scle_pkg::state_t     state;
  scle_pkg::state_t     state_next;
  scle_pkg::req_t       cmd;
  scle_pkg::cell_ctl_t  ctl;
  scle_pkg::cell_link_t link [LIST_DEPTH + 1];
  logic signed [7:0]    entry [LIST_DEPTH];
  logic [CW-1:0]        count;
  logic [CW-1:0]        count_next;
  logic                 commit;
  logic                 full;
  logic                 empty;
  logic                 found;
  logic [1:0]           status;
  logic                 rsp_valid_next;

  assign link[0] = '0;

  for (genvar i = 0; i < LIST_DEPTH; i++) begin : g_cell
    logic signed [7:0] left_entry;
    logic signed [7:0] right_entry;
    logic              occupied;

    if (i == 0) begin : g_first
      assign left_entry = entry[i];
    end else begin : g_mid_l
      assign left_entry = entry[i-1];
    end
    if (i == LIST_DEPTH - 1) begin : g_last
      assign right_entry = entry[i];
    end else begin : g_mid_r
      assign right_entry = entry[i+1];
    end
    assign occupied = (CW'(i) < count);

    scle_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .value       (cmd.value),
      .replacement (cmd.replacement),
      .occupied    (occupied),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .link_in     (link[i]),
      .link_out    (link[i+1]),
      .entry       (entry[i])
    );
  end

  assign full  = (count == CW'(LIST_DEPTH));
  assign empty = (count == '0);
  assign found = link[LIST_DEPTH].eq_seen;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= scle_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    commit     = 1'b0;
    unique case (state)
      scle_pkg::S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          state_next = scle_pkg::S_EXEC;
        end
      end
      scle_pkg::S_EXEC: begin
        if (!rsp_valid || rsp_ready) begin
          commit     = 1'b1;
          state_next = scle_pkg::S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    status = scle_pkg::ST_NOT_FOUND;
    ctl    = '0;
    unique case (cmd.op)
      scle_pkg::OP_INSERT: begin
        status     = full ? scle_pkg::ST_FULL : scle_pkg::ST_DONE;
        ctl.insert = commit && !full;
      end
      scle_pkg::OP_DELETE: begin
        status     = empty ? scle_pkg::ST_EMPTY :
                     (found ? scle_pkg::ST_DONE : scle_pkg::ST_NOT_FOUND);
        ctl.remove = commit && found;
      end
      scle_pkg::OP_REPLACE: begin
        status      = empty ? scle_pkg::ST_EMPTY :
                      (found ? scle_pkg::ST_DONE : scle_pkg::ST_NOT_FOUND);
        ctl.replace = commit && found;
      end
      default: begin
        status = scle_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  always_comb begin
    count_next = count;
    if (ctl.insert) begin
      count_next = count + CW'(1);
    end else if (ctl.remove) begin
      count_next = count - CW'(1);
    end
  end

  assign rsp_valid_next = commit ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid);

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      count     <= count_next;
      rsp_valid <= rsp_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      cmd <= req;
    end
    if (commit) begin
      rsp.status      <= status;
      rsp.entry_count <= 5'(count_next);
    end
  end

  `ASSERT_PROP(a_count_bound, clk, rst, count <= CW'(LIST_DEPTH))
  `ASSERT_PROP(a_count_idle, clk, rst, (state != scle_pkg::S_EXEC) |=> $stable(count))
  `ASSERT_PROP(a_rsp_from_exec, clk, rst, $rose(rsp_valid) |-> $past(state) == scle_pkg::S_EXEC)
  `ASSERT_NEVER(a_ctl_excl, clk, rst, !$onehot0({ctl.insert, ctl.remove, ctl.replace}))

endmodule

// ===== tb/tb_sorted_char_list_engine.sv =====
`timescale 1ns / 100ps

module tb_sorted_char_list_engine;

  localparam int DEPTH = 16;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam int RANDOM_ITEMS = 2000;
  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_OFF = 120;
  localparam int SETTLE = 8;

  typedef struct packed {
    scle_pkg::req_t item;
    logic           known;
    scle_pkg::rsp_t result;
  } dir_row_t;

  localparam int NUM_DIRECTED = 27;
  localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
    '{'{scle_pkg::OP_DELETE, 8'sd5, 8'sd0}, 1'b1, '{scle_pkg::ST_EMPTY, 5'd0}},
    '{'{scle_pkg::OP_REPLACE, 8'sd5, 8'sd6}, 1'b1, '{scle_pkg::ST_EMPTY, 5'd0}},
    '{'{OP_SPARE, 8'sh55, 8'shaa}, 1'b1, '{scle_pkg::ST_NOT_FOUND, 5'd0}},
    '{'{scle_pkg::OP_INSERT, 8'sh80, 8'sd0}, 1'b1, '{scle_pkg::ST_DONE, 5'd1}},
    '{'{scle_pkg::OP_INSERT, 8'sh7f, 8'sd0}, 1'b1, '{scle_pkg::ST_DONE, 5'd2}},
    '{'{scle_pkg::OP_INSERT, 8'sd0, 8'sd0}, 1'b1, '{scle_pkg::ST_DONE, 5'd3}},
    '{'{scle_pkg::OP_INSERT, 8'sd0, 8'sh7f}, 1'b1, '{scle_pkg::ST_DONE, 5'd4}},
    '{'{scle_pkg::OP_DELETE, 8'sd55, 8'sd0}, 1'b1, '{scle_pkg::ST_NOT_FOUND, 5'd4}},
    '{'{scle_pkg::OP_REPLACE, 8'sd0, 8'shff}, 1'b1, '{scle_pkg::ST_DONE, 5'd4}},
    '{'{scle_pkg::OP_REPLACE, 8'sd99, 8'sd1}, 1'b1, '{scle_pkg::ST_NOT_FOUND, 5'd4}},
    '{'{scle_pkg::OP_DELETE, 8'sh7f, 8'sd0}, 1'b1, '{scle_pkg::ST_DONE, 5'd3}},
    '{'{scle_pkg::OP_REPLACE, 8'sh80, 8'sh7f}, 1'b0, '0},
    '{'{scle_pkg::OP_INSERT, 8'sh55, 8'sd0}, 1'b0, '0},
    '{'{scle_pkg::OP_INSERT, 8'shaa, 8'sd0}, 1'b0, '0},
    '{'{scle_pkg::OP_INSERT, 8'sd1, 8'sd0}, 1'b0, '0},
    '{'{scle_pkg::OP_INSERT, 8'sd2, 8'sd0}, 1'b0, '0},
    '{'{scle_pkg::OP_INSERT, 8'shfe, 8'sd0}, 1'b0, '0},
    '{'{scle_pkg::OP_INSERT, 8'sd3, 8'sd0}, 1'b0, '0},
    '{'{scle_pkg::OP_INSERT, 8'shfd, 8'sd0}, 1'b0, '0},
    '{'{scle_pkg::OP_INSERT, 8'sd64, 8'sd0}, 1'b0, '0},
    '{'{scle_pkg::OP_INSERT, 8'shc0, 8'sd0}, 1'b0, '0},
    '{'{scle_pkg::OP_INSERT, 8'sd100, 8'sd0}, 1'b0, '0},
    '{'{scle_pkg::OP_INSERT, 8'sh9c, 8'sd0}, 1'b0, '0},
    '{'{scle_pkg::OP_INSERT, 8'sd5, 8'sd0}, 1'b0, '0},
    '{'{scle_pkg::OP_INSERT, 8'sd5, 8'sd0}, 1'b0, '0},
    '{'{scle_pkg::OP_INSERT, 8'sd7, 8'sd0}, 1'b1, '{scle_pkg::ST_FULL, 5'd16}},
    '{'{scle_pkg::OP_DELETE, 8'sd5, 8'sd0}, 1'b0, '0}
  };

  logic clk;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_ready;
  scle_pkg::req_t req = '0;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  scle_pkg::rsp_t rsp;

  // typed-in expectation travelling with the item on offer
  logic req_known = 1'b0;
  scle_pkg::rsp_t req_known_rsp = '0;

  logic signed [7:0] held_chars[$];
  scle_pkg::rsp_t pending_rsp[$];
  logic signed [7:0] recent_chars[8];
  int errors = 0;
  int results_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  sorted_char_list_engine #(
    .LIST_DEPTH(DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_ready(rsp_ready),
    .rsp(rsp)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  function automatic scle_pkg::rsp_t list_apply(input scle_pkg::req_t item);
    scle_pkg::rsp_t res;
    int pos;
    pos = 0;
    res.status = scle_pkg::ST_NOT_FOUND;
    case (item.op)
      scle_pkg::OP_INSERT: begin
        if (held_chars.size() >= DEPTH) begin
          res.status = scle_pkg::ST_FULL;
        end else begin
          while (pos < held_chars.size() && $signed(item.value) > held_chars[pos]) pos++;
          held_chars.insert(pos, item.value);
          res.status = scle_pkg::ST_DONE;
        end
      end
      scle_pkg::OP_DELETE, scle_pkg::OP_REPLACE: begin
        if (held_chars.size() == 0) begin
          res.status = scle_pkg::ST_EMPTY;
        end else begin
          while (pos < held_chars.size() && held_chars[pos] != $signed(item.value)) pos++;
          if (pos < held_chars.size()) begin
            if (item.op == scle_pkg::OP_DELETE) held_chars.delete(pos);
            else held_chars[pos] = item.replacement;
            res.status = scle_pkg::ST_DONE;
          end
        end
      end
      default: ;
    endcase
    res.entry_count = 5'(held_chars.size());
    return res;
  endfunction

  function automatic logic signed [7:0] pick_char();
    int roll;
    roll = $urandom_range(99);
    if (roll < 45) return recent_chars[$urandom_range(7)];
    if (roll < 70) return 8'($urandom_range(8)) - 8'd4;
    return 8'($urandom_range(255));
  endfunction

  // result checking, prediction and the receiving side
  always @(posedge clk) begin
    scle_pkg::rsp_t want;
    scle_pkg::rsp_t model_rsp;
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (pending_rsp.size() == 0) begin
          $display("%0t: unexpected item status=%0d entry_count=%0d", $time, rsp.status,
                   rsp.entry_count);
          errors++;
        end else begin
          want = pending_rsp.pop_front();
          if (rsp.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, rsp.status);
            errors++;
          end
          if (rsp.entry_count !== want.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d", $time, want.entry_count,
                     rsp.entry_count);
            errors++;
          end
        end
        results_seen++;
      end
      if (req_valid && req_ready) begin
        model_rsp = list_apply(req);
        pending_rsp.push_back(req_known ? req_known_rsp : model_rsp);
      end
      if (hold_left > 0) begin
        hold_left--;
      end else if (rsp_valid && rsp_ready && (results_seen == 300 || results_seen == 1500)) begin
        hold_left = HOLD_OFF;
      end
      rsp_ready <= (hold_left == 0) &&
                   ((results_seen >= 600 && results_seen < 900) || $urandom_range(99) >= 16);
    end
  end

  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL sorted_char_list_engine");
      $finish;
    end
  end

  task automatic offer(input scle_pkg::req_t item, input logic known,
                       input scle_pkg::rsp_t known_rsp, input bit calm);
    while (!calm && $urandom_range(99) < 16) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req <= item;
    req_known <= known;
    req_known_rsp <= known_rsp;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    scle_pkg::req_t item;
    int roll;
    int ins_cut;
    int del_cut;
    foreach (recent_chars[k]) recent_chars[k] = 8'sd0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < NUM_DIRECTED; k++) begin
      offer(DIRECTED[k].item, DIRECTED[k].known, DIRECTED[k].result, 1'b0);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 1000) wait_drained();
      case ((n / 100) % 3)
        0: begin ins_cut = 70; del_cut = 85; end
        1: begin ins_cut = 20; del_cut = 85; end
        default: begin ins_cut = 40; del_cut = 70; end
      endcase
      roll = $urandom_range(99);
      if (roll < ins_cut) item.op = scle_pkg::OP_INSERT;
      else if (roll < del_cut) item.op = scle_pkg::OP_DELETE;
      else if (roll < 97) item.op = scle_pkg::OP_REPLACE;
      else item.op = OP_SPARE;
      item.value = pick_char();
      item.replacement = pick_char();
      if (item.op == scle_pkg::OP_INSERT) recent_chars[$urandom_range(7)] = item.value;
      if (item.op == scle_pkg::OP_REPLACE) recent_chars[$urandom_range(7)] = item.replacement;
      offer(item, 1'b0, '0, n >= 600 && n < 900);
    end

    wait_drained();
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("PASS sorted_char_list_engine");
    end else begin
      $display("FAIL sorted_char_list_engine");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/scle_pkg.sv
rtl/scle_cell.sv
rtl/sorted_char_list_engine.sv
tb/tb_sorted_char_list_engine.sv
